>>> rtl/cgs_pkg.sv
// Shared types and codes for the checksum-guarded stack.
// No dependencies; imported by cgs_sum and checksum_guarded_stack.
`timescale 1ns / 1ps

package cgs_pkg;

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    // Widest entry index the checksum walker handles (DEPTH up to 65536)
    localparam int IDX_W = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [8:0]         depth_now;
    } rsp_t;

    // One read beat of the walk: memory data is valid with this index
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } walk_tap_t;

endpackage

>>> rtl/checksum_guarded_stack.sv
// Top level of the checksum-guarded LIFO stack.
// Depends on cgs_pkg and cgs_sum.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive req (cmd, push_value) and raise start; the item
//   is taken at a rising edge with start high and busy low. busy stays high
//   until the result has been issued.
//   Result channel: done pulses for one cycle with rsp (read_value, status,
//   depth_now). The receiver cannot stall; the result must be taken then.
//   Flow: every command first walks the live entries through the single
//   memory read port, one entry per cycle, then a two-stage multiply and
//   accumulate drains. The check alone decides a mismatch, underflow,
//   overflow or unused code; a peek then reads the top entry, and a pop
//   reads it and applies the update. A push applies the update, then walks
//   all n + 1 entries again, n being the count held before. The slowest
//   command is a push onto DEPTH - 1 entries. One command is in work at a
//   time; busy drops in the cycle that carries done.
//   Reset: count and stored checksum clear to zero; memory contents are
//   not cleared, and only entries below the count are ever read.
//   depth_now carries the low 9 bits of the entry count.
module checksum_guarded_stack #(
    parameter int DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cgs_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output cgs_pkg::rsp_t rsp
);
    import cgs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,  // waiting for a command
        S_CHK  = 4'b0010,  // checksum walk over live entries
        S_RD   = 4'b0100,  // top entry read in flight
        S_UPD  = 4'b1000   // apply checksum update after push or pop
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic [31:0]    word_reg, word_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [31:0]    cks_reg, cks_next;
    logic [CW-1:0]  walk_idx_reg, walk_idx_next;
    logic           rd_v_reg, rd_v_next;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic           post_reg, post_next;      // walk follows a push
    logic [31:0]    top_reg, top_next;
    logic [31:0]    prod_reg, prod_next;
    logic           done_reg, done_next;
    rsp_t           rsp_reg, rsp_next;

    // memory ports
    logic [31:0]    mem [DEPTH];
    logic [31:0]    rdata_reg;
    logic           rd_en, wr_en;
    logic [AW-1:0]  rd_addr, wr_addr;

    logic [31:0]    walk_sum;
    logic           sum_busy;
    logic           sum_clr;
    walk_tap_t      tap;

    logic [CW-1:0]  cnt_m1;
    logic           walk_end;

    assign cnt_m1   = count_reg - CW'(1);
    assign walk_end = (walk_idx_reg == count_reg) && !rd_v_reg && !sum_busy;

    assign tap.valid = rd_v_reg;
    assign tap.idx   = IDX_W'(rd_idx_reg);

    cgs_sum u_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (sum_clr),
        .tap   (tap),
        .data  (rdata_reg),
        .sum   (walk_sum),
        .busy  (sum_busy)
    );

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        word_next     = word_reg;
        count_next    = count_reg;
        cks_next      = cks_reg;
        walk_idx_next = walk_idx_reg;
        rd_v_next     = 1'b0;
        rd_idx_next   = rd_idx_reg;
        post_next     = post_reg;
        top_next      = top_reg;
        prod_next     = prod_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        rd_en         = 1'b0;
        rd_addr       = AW'(cnt_m1);
        wr_en         = 1'b0;
        wr_addr       = AW'(count_reg);
        sum_clr       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = req.cmd;
                    word_next     = req.push_value;
                    walk_idx_next = '0;
                    post_next     = 1'b0;
                    sum_clr       = 1'b1;
                    state_next    = S_CHK;
                end
            end

            S_CHK:
            begin
                if (walk_idx_reg < count_reg)
                begin
                    // issue the next entry of the walk
                    rd_en         = 1'b1;
                    rd_addr       = walk_idx_reg[AW-1:0];
                    rd_v_next     = 1'b1;
                    rd_idx_next   = walk_idx_reg[AW-1:0];
                    walk_idx_next = walk_idx_reg + CW'(1);
                end
                else if (walk_end)
                begin
                    rsp_next.read_value = '0;
                    rsp_next.depth_now  = 9'(count_reg);
                    if (walk_sum != cks_reg)
                    begin
                        rsp_next.status = ST_MISMATCH;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (post_reg)
                    begin
                        rsp_next.status = ST_OK;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_PUSH:
                            begin
                                if (count_reg >= CW'(DEPTH))
                                begin
                                    rsp_next.status = ST_OVERFLOW;
                                    done_next       = 1'b1;
                                    state_next      = S_IDLE;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    prod_next  = 32'(word_reg * count_reg);
                                    state_next = S_UPD;
                                end
                            end
                            CMD_POP, CMD_PEEK:
                            begin
                                if (count_reg == '0)
                                begin
                                    rsp_next.status = ST_UNDERFLOW;
                                    done_next       = 1'b1;
                                    state_next      = S_IDLE;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    state_next = S_RD;
                                end
                            end
                            default:
                            begin
                                rsp_next.status = ST_OK;
                                done_next       = 1'b1;
                                state_next      = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_RD:
            begin
                top_next = rdata_reg;
                if (cmd_reg == CMD_PEEK)
                begin
                    rsp_next.read_value = rdata_reg;
                    rsp_next.status     = ST_OK;
                    rsp_next.depth_now  = 9'(count_reg);
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    prod_next  = 32'(rdata_reg * cnt_m1);
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                if (cmd_reg == CMD_PUSH)
                begin
                    cks_next      = cks_reg + prod_reg;
                    count_next    = count_reg + CW'(1);
                    walk_idx_next = '0;
                    post_next     = 1'b1;
                    sum_clr       = 1'b1;
                    state_next    = S_CHK;
                end
                else
                begin
                    cks_next            = cks_reg - prod_reg;
                    count_next          = cnt_m1;
                    rsp_next.read_value = top_reg;
                    rsp_next.status     = ST_OK;
                    rsp_next.depth_now  = 9'(cnt_m1);
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cks_reg      <= 32'd0;
            walk_idx_reg <= '0;
            rd_v_reg     <= 1'b0;
            post_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cks_reg      <= cks_next;
            walk_idx_reg <= walk_idx_next;
            rd_v_reg     <= rd_v_next;
            post_reg     <= post_next;
            done_reg     <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        word_reg   <= word_next;
        rd_idx_reg <= rd_idx_next;
        top_reg    <= top_next;
        prod_reg   <= prod_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/cgs_sum.sv
// Weighted checksum accumulator: sum of index * word, modulo 2^32.
// Depends on cgs_pkg.
`timescale 1ns / 1ps

module cgs_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  cgs_pkg::walk_tap_t tap,
    input  logic [31:0]       data,
    output logic [31:0]       sum,
    output logic              busy
);
    import cgs_pkg::*;

    logic [31:0] prod_reg;
    logic        prod_v_reg;
    logic [31:0] acc_reg;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= tap.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap.valid)
        begin
            prod_reg <= 32'(data * {16'd0, tap.idx});
        end
    end

    // accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 32'd0;
        end
        else if (clr)
        begin
            acc_reg <= 32'd0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign sum  = acc_reg;
    assign busy = prod_v_reg;

endmodule
